// File: rtl/fumi_pkg.sv
package fumi_pkg;

  localparam int DEF_ENTRIES    = 128;
  localparam int DEF_VALUE_BITS = 16;

  localparam int ACTION_W   = 2;
  localparam int VALUE_W    = 16;
  localparam int STATUS_W   = 3;
  localparam int POSITION_W = 7;

  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_STORED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MATCHED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

endpackage

// File: rtl/fumi_req_if.sv
interface fumi_req_if import fumi_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [VALUE_W-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface

// File: rtl/fumi_rsp_if.sv
interface fumi_rsp_if import fumi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [POSITION_W-1:0] position;

  modport source (output valid, output status, output position, input ready);
  modport sink (input valid, input status, input position, output ready);
endinterface

// File: rtl/first_unused_match_index_mapper.sv
// First-unused-match index mapper.
// Requests arrive on req (action, value) and every request gives exactly
// one result on rsp (status, position), both valid/ready handshakes.
// Load appends a value to the table, query claims the lowest unused entry
// holding the same value, clear empties the table.
// Latency: load and clear show their result in the cycle after acceptance.
// A query reads one table entry per cycle through the single read port of
// the table memory and compares it in the next cycle; an early hit stops
// the scan. Throughput is one request per result, set by that scan.
// req.ready is low while a query scans and while a result waits on a
// stalled receiver with no room behind it; a result holds on rsp until
// taken, and the next request is taken in the cycle that result leaves.
// Reset empties the table at once: only the fill count and control state
// clear, as entries beyond the fill count are never read and a load
// rewrites the used mark of its entry.
module first_unused_match_index_mapper import fumi_pkg::*; #(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input logic       clk,
  input logic       rst,
  fumi_req_if.sink  req,
  fumi_rsp_if.source rsp
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SB = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  localparam logic STATE_IDLE = 1'b0;
  localparam logic STATE_SCAN = 1'b1;

  logic [SB:0]           mem [ENTRIES];
  logic                  state;
  logic [CW-1:0]         fill_count;
  logic [CW-1:0]         issue_idx;
  logic                  chk_valid;
  logic [AW-1:0]         chk_idx;
  logic [SB-1:0]         query;
  logic [SB:0]           rd_data;
  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [POSITION_W-1:0] out_position;

  logic                  accept;
  logic [SB-1:0]         req_val;
  logic                  issue;
  logic                  hit;
  logic                  done;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [SB:0]           wr_data;

  assign req.ready    = (state == STATE_IDLE) && (!out_valid || rsp.ready);
  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.position = out_position;

  always_comb begin
    accept  = req.valid && req.ready;
    req_val = req.value[SB-1:0];
    issue   = (state == STATE_SCAN) && (issue_idx < fill_count);
    hit     = (state == STATE_SCAN) && chk_valid && !rd_data[SB] &&
              (rd_data[SB-1:0] == query);
    done    = (accept && (req.action != ACT_QUERY)) || hit ||
              ((state == STATE_SCAN) && !chk_valid && !issue);
    wr_en   = 1'b0;
    wr_addr = chk_idx;
    wr_data = {1'b1, query};
    if (accept && (req.action == ACT_LOAD) && (fill_count < FULL)) begin
      wr_en   = 1'b1;
      wr_addr = fill_count[AW-1:0];
      wr_data = {1'b0, req_val};
    end else if (hit) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data <= mem[issue_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (rsp.valid && rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= STATE_IDLE;
      fill_count <= '0;
      issue_idx  <= '0;
      chk_valid  <= 1'b0;
    end else begin
      case (state)
        STATE_IDLE: begin
          if (accept) begin
            case (req.action)
              ACT_LOAD: begin
                if (fill_count < FULL) begin
                  fill_count   <= fill_count + CW'(1);
                  out_status   <= ST_STORED;
                  out_position <= POSITION_W'(fill_count);
                end else begin
                  out_status   <= ST_FULL;
                  out_position <= '0;
                end
              end
              ACT_QUERY: begin
                query     <= req_val;
                issue_idx <= '0;
                chk_valid <= 1'b0;
                state     <= STATE_SCAN;
              end
              default: begin
                fill_count   <= '0;
                out_status   <= ST_CLEARED;
                out_position <= '0;
              end
            endcase
          end
        end
        STATE_SCAN: begin
          chk_valid <= issue;
          chk_idx   <= issue_idx[AW-1:0];
          if (issue) begin
            issue_idx <= issue_idx + CW'(1);
          end
          if (hit) begin
            out_status   <= ST_MATCHED;
            out_position <= POSITION_W'(chk_idx);
            state        <= STATE_IDLE;
          end else if (!chk_valid && !issue) begin
            out_status   <= ST_NOMATCH;
            out_position <= '0;
            state        <= STATE_IDLE;
          end
        end
        default: begin
          state <= STATE_IDLE;
        end
      endcase
    end
  end

endmodule
